// ===== sv/bfsp_pkg.sv =====
package bfsp_pkg;

  // Fixed field widths of the item and result payloads.
  localparam int unsigned VTX_W  = 6;
  localparam int unsigned DIST_W = 24;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned VCNT_W = 7;

  // Configuration port.
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 7;
  localparam logic [CFG_AW-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_SOURCE_VERTEX = 1'd1;

  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST  = 7'd64;
  localparam logic [VTX_W-1:0]  SOURCE_VERTEX_RST = 6'd0;

  // Saturation bounds of a distance.
  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INIT     = 9'b000000010,
    S_FETCH    = 9'b000000100,
    S_LOOKUP   = 9'b000001000,
    S_RELAX    = 9'b000010000,
    S_OUT_RD   = 9'b000100000,
    S_OUT_LOAD = 9'b001000000,
    S_OUT_SEND = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic store;     // write the accepted edge into the edge store
    logic v_clr;     // vertex counter to zero
    logic v_inc;     // vertex counter up by one
    logic init_wr;   // write the initial entry of the current vertex
    logic pass_set;  // start of relaxation: pass 1, edge 0
    logic e_clr;     // edge counter to zero
    logic e_inc;     // edge counter up by one
    logic pass_inc;  // pass counter up by one
    logic edge_rd;   // read the current edge
    logic vert_rd;   // read tail and head vertex entries
    logic relax;     // relax the edge that was read
    logic out_rd;    // read the entry of the current vertex
    logic out_load;  // load the result register
    logic finish;    // run done: clear edge count and overflow
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic v_last;
    logic e_last;
    logic pass_last;
    logic no_pass;
  } status_t;

endpackage

// ===== sv/bfsp_ctrl.sv =====
module bfsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tlast,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  bfsp_pkg::status_t status_i,
  output bfsp_pkg::cmd_t    cmd_o
);

  bfsp_pkg::state_e state_q, state_d;
  logic             in_acc;
  logic             out_acc;

  assign s_axis_tready = (state_q == bfsp_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == bfsp_pkg::S_OUT_SEND);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bfsp_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_o.store = 1'b1;
          if (s_axis_tlast) begin
            cmd_o.v_clr = 1'b1;
            state_d     = bfsp_pkg::S_INIT;
          end
        end
      end
      bfsp_pkg::S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.v_last) begin
          cmd_o.pass_set = 1'b1;
          if (status_i.no_pass) begin
            cmd_o.v_clr = 1'b1;
            state_d     = bfsp_pkg::S_OUT_RD;
          end else begin
            state_d = bfsp_pkg::S_FETCH;
          end
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      bfsp_pkg::S_FETCH: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = bfsp_pkg::S_LOOKUP;
      end
      bfsp_pkg::S_LOOKUP: begin
        cmd_o.vert_rd = 1'b1;
        state_d       = bfsp_pkg::S_RELAX;
      end
      bfsp_pkg::S_RELAX: begin
        cmd_o.relax = 1'b1;
        if (status_i.e_last) begin
          cmd_o.e_clr = 1'b1;
          if (status_i.pass_last) begin
            cmd_o.v_clr = 1'b1;
            state_d     = bfsp_pkg::S_OUT_RD;
          end else begin
            cmd_o.pass_inc = 1'b1;
            state_d        = bfsp_pkg::S_FETCH;
          end
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = bfsp_pkg::S_FETCH;
        end
      end
      bfsp_pkg::S_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = bfsp_pkg::S_OUT_LOAD;
      end
      bfsp_pkg::S_OUT_LOAD: begin
        cmd_o.out_load = 1'b1;
        state_d        = bfsp_pkg::S_OUT_SEND;
      end
      bfsp_pkg::S_OUT_SEND: begin
        if (out_acc) begin
          if (status_i.v_last) begin
            cmd_o.finish = 1'b1;
            state_d      = bfsp_pkg::S_IDLE;
          end else begin
            cmd_o.v_inc = 1'b1;
            state_d     = bfsp_pkg::S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = bfsp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfsp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // Input and output sides are never open at the same time.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is shown");

  // The last edge starts the initialization sweep.
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_q == bfsp_pkg::S_INIT))
    else $error("last edge did not start a run");

  // Taking the final result reopens the input side.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && status_i.v_last) |=> s_axis_tready)
    else $error("block not idle after the final result");
`endif

endmodule

// ===== sv/bfsp_dpath.sv =====
module bfsp_dpath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfsp_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [bfsp_pkg::CFG_DW-1:0]         cfg_wdata_i,
  input  logic [bfsp_pkg::VTX_W-1:0]          from_vertex_i,
  input  logic [bfsp_pkg::VTX_W-1:0]          to_vertex_i,
  input  logic signed [bfsp_pkg::WGT_W-1:0]   edge_weight_i,
  input  bfsp_pkg::cmd_t                      cmd_i,
  output bfsp_pkg::status_t                   status_o,
  output logic [bfsp_pkg::VTX_W-1:0]          vertex_o,
  output logic signed [bfsp_pkg::DIST_W-1:0]  distance_o,
  output logic [bfsp_pkg::VTX_W-1:0]          predecessor_o,
  output logic                                reachable_o,
  output logic                                edges_dropped_o,
  output logic                                last_result_o
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned VW  = bfsp_pkg::VTX_W;
  localparam int unsigned DW  = bfsp_pkg::DIST_W;
  localparam int unsigned WW  = bfsp_pkg::WGT_W;
  localparam int unsigned MW  = 1 + VW + DW;

  // Configuration.
  logic [bfsp_pkg::VCNT_W-1:0] vcount_q;
  logic [VW-1:0]               source_q;
  logic [CW-1:0]               nv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= bfsp_pkg::VERTEX_COUNT_RST;
      source_q <= bfsp_pkg::SOURCE_VERTEX_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bfsp_pkg::REG_VERTEX_COUNT:  vcount_q <= cfg_wdata_i[bfsp_pkg::VCNT_W-1:0];
        bfsp_pkg::REG_SOURCE_VERTEX: source_q <= cfg_wdata_i[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcount_q == '0) begin
      nv = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      nv = CW'(MAX_VERTICES);
    end else begin
      nv = CW'(vcount_q);
    end
  end

  // Counters and edge bookkeeping.
  logic [ECW-1:0] ecount_q;
  logic           overflow_q;
  logic [EAW-1:0] e_q;
  logic [CW-1:0]  pass_q;
  logic [CW-1:0]  v_q;
  logic           store_room;

  assign store_room = (32'(ecount_q) < MAX_EDGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q   <= '0;
      overflow_q <= 1'b0;
      e_q        <= '0;
      pass_q     <= '0;
      v_q        <= '0;
    end else begin
      if (cmd_i.finish) begin
        ecount_q   <= '0;
        overflow_q <= 1'b0;
      end else if (cmd_i.store) begin
        if (store_room) begin
          ecount_q <= ECW'(ecount_q + 1'b1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.pass_set || cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= EAW'(e_q + 1'b1);
      end
      if (cmd_i.pass_set) begin
        pass_q <= CW'(1);
      end else if (cmd_i.pass_inc) begin
        pass_q <= CW'(pass_q + 1'b1);
      end
      if (cmd_i.v_clr) begin
        v_q <= '0;
      end else if (cmd_i.v_inc) begin
        v_q <= CW'(v_q + 1'b1);
      end
    end
  end

  assign status_o.v_last    = (v_q == CW'(nv - 1'b1));
  assign status_o.e_last    = ((32'(e_q) + 32'd1) == 32'(ecount_q));
  assign status_o.pass_last = (pass_q == CW'(nv - 1'b1));
  assign status_o.no_pass   = (nv == CW'(1)) || (ecount_q == '0);

  // Edge store.
  logic [VW-1:0]        tail_mem [MAX_EDGES];
  logic [VW-1:0]        head_mem [MAX_EDGES];
  logic signed [WW-1:0] wgt_mem  [MAX_EDGES];
  logic [VW-1:0]        tail_q;
  logic [VW-1:0]        head_q;
  logic signed [WW-1:0] wgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_room) begin
      tail_mem[EAW'(ecount_q)] <= from_vertex_i;
      head_mem[EAW'(ecount_q)] <= to_vertex_i;
      wgt_mem[EAW'(ecount_q)]  <= edge_weight_i;
    end
    if (cmd_i.edge_rd) begin
      tail_q <= tail_mem[e_q];
      head_q <= head_mem[e_q];
      wgt_q  <= wgt_mem[e_q];
    end
  end

  // Vertex store: {reached, predecessor, distance} per vertex.
  logic [MW-1:0] vtx_mem [MAX_VERTICES];
  logic [MW-1:0] rdu_q;
  logic [MW-1:0] rdv_q;
  logic [AW-1:0] rdu_addr;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  assign rdu_addr = cmd_i.out_rd ? v_q[AW-1:0] : AW'(tail_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtx_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.vert_rd || cmd_i.out_rd) begin
      rdu_q <= vtx_mem[rdu_addr];
    end
    if (cmd_i.vert_rd) begin
      rdv_q <= vtx_mem[AW'(head_q)];
    end
  end

  // Relaxation of one edge.
  logic                 ru;
  logic                 rv;
  logic signed [DW-1:0] du;
  logic signed [DW-1:0] dv;
  logic signed [DW:0]   sum;
  logic signed [DW-1:0] cand;
  logic                 edge_ok;
  logic                 relax_we;
  logic                 src_hit;

  assign ru  = rdu_q[MW-1];
  assign du  = rdu_q[DW-1:0];
  assign rv  = rdv_q[MW-1];
  assign dv  = rdv_q[DW-1:0];
  assign sum = {du[DW-1], du} + (DW+1)'(wgt_q);

  always_comb begin
    if (sum[DW] != sum[DW-1]) begin
      cand = sum[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
    end else begin
      cand = sum[DW-1:0];
    end
  end

  assign edge_ok  = (32'(tail_q) < 32'(nv)) && (32'(head_q) < 32'(nv)) && ru;
  assign relax_we = cmd_i.relax && edge_ok && (!rv || (cand < dv));
  assign src_hit  = (32'(v_q) == 32'(source_q));

  always_comb begin
    if (cmd_i.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = v_q[AW-1:0];
      wr_data = {src_hit, source_q, {DW{1'b0}}};
    end else begin
      wr_en   = relax_we;
      wr_addr = AW'(head_q);
      wr_data = {1'b1, tail_q, cand};
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      vertex_o        <= VW'(v_q);
      reachable_o     <= ru;
      distance_o      <= ru ? du : '0;
      predecessor_o   <= ru ? rdu_q[MW-2:DW] : '0;
      edges_dropped_o <= overflow_q;
      last_result_o   <= status_o.v_last;
    end
  end

`ifndef SYNTH
  // A finished run leaves an empty edge store behind.
  a_finish_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (ecount_q == '0) && !overflow_q)
    else $error("edge count not cleared after a run");

  // The edge count never passes the store capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecount_q) <= MAX_EDGES)
    else $error("edge count beyond capacity");

  // Results are only taken for vertices in use.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (32'(v_q) < 32'(nv)))
    else $error("result for a vertex not in use");
`endif

endmodule

// ===== sv/bellman_ford_shortest_paths_top.sv =====
// Edges load at one item per cycle while no run is in progress; an item without the
// last mark causes no result. After the last edge: an initialization sweep over nv
// vertices, then (nv-1) passes over the stored edges (edge read, vertex read, then
// relax/write on the single vertex write port), then nv results (read, load, show).
// Reset (asynchronous, active low) clears the sequencer, edge count, overflow flag and
// sets vertex_count to 64 and source_vertex to 0; the stores need no clearing pass.
module bellman_ford_shortest_paths_top #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port: index 0 is vertex_count, index 1 is source_vertex.
  input  logic                                cfg_we_i,
  input  logic [bfsp_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [bfsp_pkg::CFG_DW-1:0]         cfg_wdata_i,
  // Edge stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // from_vertex [5:0], to_vertex [11:6], edge_weight [27:12], zero [31:28]
  input  logic [bfsp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,   // last_edge
  // Result stream, one item per vertex.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // vertex [5:0], distance [29:6], predecessor [35:30], reachable [36],
  // edges_dropped [37], zero [39:38]
  output logic [bfsp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast    // last_result
);

  bfsp_pkg::cmd_t    cmd;
  bfsp_pkg::status_t status;

  logic [bfsp_pkg::VTX_W-1:0]         vertex;
  logic signed [bfsp_pkg::DIST_W-1:0] distance;
  logic [bfsp_pkg::VTX_W-1:0]         predecessor;
  logic                               reachable;
  logic                               edges_dropped;

  // The sequencer owns both handshakes; the input side is open only while no run is
  // in progress, so an edge never lands in the store while passes read it.
  bfsp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // The datapath holds the configuration, the edge store, the per-vertex store and the
  // adder/comparator that relaxes one edge, plus the result register.
  bfsp_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .from_vertex_i   (s_axis_tdata[5:0]),
    .to_vertex_i     (s_axis_tdata[11:6]),
    .edge_weight_i   (s_axis_tdata[27:12]),
    .cmd_i           (cmd),
    .status_o        (status),
    .vertex_o        (vertex),
    .distance_o      (distance),
    .predecessor_o   (predecessor),
    .reachable_o     (reachable),
    .edges_dropped_o (edges_dropped),
    .last_result_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, edges_dropped, reachable, predecessor, distance, vertex};

endmodule
